// File: src/cpuavg_pkg.sv
// Shared widths and constants for the CPU load window average block.
`default_nettype none

package cpuavg_pkg;

  // Counter snapshot and derived widths
  localparam int CNT_W      = 64;
  localparam int TOTAL_W    = CNT_W + 1;
  localparam int LOAD_W     = 8;
  // Scaled busy time: busy * (2**LOAD_W - 1) needs LOAD_W extra bits
  localparam int SCALED_W   = TOTAL_W + LOAD_W;

  // Window configuration
  localparam int WLEN_W     = 9;
  localparam int MAX_WINDOW = 256;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W      = 16;

  // Step counter covers the longest phase (one bit per cycle over the scaled word)
  localparam int STEP_W      = 7;
  localparam int SERIAL_LAST = SCALED_W - 1;

endpackage

`default_nettype wire

// File: src/cpuavg_sample_if.sv
// Valid/ready channels for counter snapshots and load results.
`default_nettype none

interface cpuavg_sample_if import cpuavg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  idle_total;
  logic [CNT_W-1:0]  kernel_total;
  logic [CNT_W-1:0]  user_total;

  modport source (output valid, output idle_total, output kernel_total,
                  output user_total, input ready);
  modport sink   (input valid, input idle_total, input kernel_total,
                  input user_total, output ready);
endinterface

interface cpuavg_result_if import cpuavg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LOAD_W-1:0] instant_load;
  logic [LOAD_W-1:0] average_load;

  modport source (output valid, output instant_load, output average_load, input ready);
  modport sink   (input valid, input instant_load, input average_load, output ready);
endinterface

`default_nettype wire

// File: src/cpuavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cpuavg_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/cpu_load_window_average_core.sv
// Top level: CPU load from counter snapshots and its windowed floor mean.
//
// Each accepted beat carries three cumulative counters (idle, kernel, user).
// The block forms the deltas to the previous beat, total = kernel + user
// (65 bits) and busy = total - idle, and reports instant_load =
// floor(busy * 255 / total), which is 0 when total is zero or idle exceeds
// total. Each load enters a ring of window_length samples (0 acts as 1,
// above 256 acts as 256) and average_load is the floor mean over the whole
// window, cleared zeros included. Writing window_length clears the ring.
// Each beat passes from acceptance to result through bit-serial
// subtract/add/scale over the counter words, restoring division for the
// load, a ring update, restoring division for the mean and the step that
// presents the result. A new beat is taken once the previous one has
// moved to the output register.
`default_nettype none

module cpu_load_window_average_core
  import cpuavg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [WLEN_W-1:0] cfg_data,
  cpuavg_sample_if.sink          sample,
  cpuavg_result_if.source        result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SERIAL,
    ST_DIVL,
    ST_UPDATE,
    ST_DIVA,
    ST_DONE
  } state_t;

  state_t state;
  logic [STEP_W-1:0] cnt;

  // Configuration and window state
  logic [WLEN_W-1:0]     wlen;
  logic [RING_AW-1:0]    pos;
  logic [SUM_W-1:0]      window_sum;
  logic [MAX_WINDOW-1:0] ring_vld;

  // Serial front end
  logic [CNT_W-1:0]    cur_idle, cur_kern, cur_user;
  logic [CNT_W-1:0]    prev_idle, prev_kern, prev_user;
  logic                bi, bk, bu, tc, bb, nb, tnz;
  logic [LOAD_W-1:0]   busy_dly;
  logic [TOTAL_W-1:0]  total_sr;
  logic [SCALED_W-1:0] n_sr;

  // Load division
  logic [TOTAL_W-1:0] rem;
  logic [LOAD_W-1:0]  nlow;
  logic [LOAD_W-1:0]  quo;

  // Mean division
  logic [SUM_W-1:0]  avg_sr;
  logic [WLEN_W-1:0] arem;
  logic [LOAD_W-1:0] inst_load;

  // Output register
  logic              out_valid;
  logic [LOAD_W-1:0] out_inst;
  logic [LOAD_W-1:0] out_avg;

  // Ring memory
  logic [LOAD_W-1:0] ring_rdata;

  // Combinational signals
  logic              live;
  logic              di, dk, du, t, b, nbit;
  logic              bi_next, bk_next, bu_next, tc_next, bb_next, nb_next;
  logic [TOTAL_W:0]  rr, rr_diff;
  logic              rr_ge;
  logic [WLEN_W:0]   arr, arr_diff;
  logic              arr_ge;
  logic [WLEN_W-1:0] n_eff;
  logic [RING_AW-1:0] pos_eff;
  logic [WLEN_W-1:0] pos_inc;
  logic [LOAD_W-1:0] old_load;
  logic [LOAD_W-1:0] load;
  logic [SUM_W-1:0]  window_sum_next;

  // Effective window length and ring slot
  always_comb begin
    if (wlen == '0) begin
      n_eff = WLEN_W'(1);
    end else if (wlen > WLEN_W'(MAX_WINDOW)) begin
      n_eff = WLEN_W'(MAX_WINDOW);
    end else begin
      n_eff = wlen;
    end
    pos_eff  = ({1'b0, pos} >= n_eff) ? '0 : pos;
    pos_inc  = {1'b0, pos_eff} + WLEN_W'(1);
    old_load = ring_vld[pos_eff] ? ring_rdata : '0;
    load     = (!tnz || bb) ? '0 : quo;
    window_sum_next = window_sum - SUM_W'(old_load) + SUM_W'(load);
  end

  // Bit-serial deltas, total, busy and busy * 255
  always_comb begin
    live = (cnt < STEP_W'(CNT_W));
    di = live & (cur_idle[0] ^ prev_idle[0] ^ bi);
    dk = live & (cur_kern[0] ^ prev_kern[0] ^ bk);
    du = live & (cur_user[0] ^ prev_user[0] ^ bu);
    bi_next = (~cur_idle[0] & prev_idle[0]) | (~(cur_idle[0] ^ prev_idle[0]) & bi);
    bk_next = (~cur_kern[0] & prev_kern[0]) | (~(cur_kern[0] ^ prev_kern[0]) & bk);
    bu_next = (~cur_user[0] & prev_user[0]) | (~(cur_user[0] ^ prev_user[0]) & bu);
    t       = dk ^ du ^ tc;
    tc_next = (dk & du) | (dk & tc) | (du & tc);
    b       = t ^ di ^ bb;
    bb_next = (~t & di) | (~(t ^ di) & bb);
    nbit    = busy_dly[0] ^ b ^ nb;
    nb_next = (~busy_dly[0] & b) | (~(busy_dly[0] ^ b) & nb);
  end

  // Restoring division steps
  always_comb begin
    rr       = {rem, nlow[LOAD_W-1]};
    rr_ge    = (rr >= {1'b0, total_sr});
    rr_diff  = rr - {1'b0, total_sr};
    arr      = {arem, avg_sr[SUM_W-1]};
    arr_ge   = (arr >= {1'b0, n_eff});
    arr_diff = arr - {1'b0, n_eff};
  end

  cpuavg_ram #(
    .Width (LOAD_W),
    .Depth (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (pos_eff),
    .wdata (load),
    .raddr (pos_eff),
    .rdata (ring_rdata)
  );

  assign sample.ready        = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.instant_load = out_inst;
  assign result.average_load = out_avg;

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      wlen       <= WLEN_W'(1);
      pos        <= '0;
      window_sum <= '0;
      ring_vld   <= '0;
      out_valid  <= 1'b0;
      prev_idle  <= '0;
      prev_kern  <= '0;
      prev_user  <= '0;
    end else begin
      // Drop the result once taken, unless the next one replaces it
      if (out_valid && result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      // Configuration write clears the window
      if (cfg_write) begin
        wlen       <= cfg_data;
        pos        <= '0;
        window_sum <= '0;
        ring_vld   <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            cur_idle <= sample.idle_total;
            cur_kern <= sample.kernel_total;
            cur_user <= sample.user_total;
            {bi, bk, bu, tc, bb, nb, tnz} <= '0;
            busy_dly <= '0;
            cnt      <= '0;
            state    <= ST_SERIAL;
          end
        end
        ST_SERIAL: begin
          // Advance one bit of every word
          if (live) begin
            cur_idle  <= cur_idle >> 1;
            cur_kern  <= cur_kern >> 1;
            cur_user  <= cur_user >> 1;
            prev_idle <= {cur_idle[0], prev_idle[CNT_W-1:1]};
            prev_kern <= {cur_kern[0], prev_kern[CNT_W-1:1]};
            prev_user <= {cur_user[0], prev_user[CNT_W-1:1]};
          end
          if (cnt < STEP_W'(TOTAL_W)) begin
            total_sr <= {t, total_sr[TOTAL_W-1:1]};
          end
          bi       <= bi_next;
          bk       <= bk_next;
          bu       <= bu_next;
          tc       <= tc_next;
          bb       <= bb_next;
          nb       <= nb_next;
          tnz      <= tnz | t;
          busy_dly <= {b, busy_dly[LOAD_W-1:1]};
          n_sr     <= {nbit, n_sr[SCALED_W-1:1]};
          if (cnt == STEP_W'(SERIAL_LAST)) begin
            // Upper part of the scaled word seeds the remainder
            rem   <= {nbit, n_sr[SCALED_W-1:LOAD_W+1]};
            nlow  <= n_sr[LOAD_W:1];
            cnt   <= '0;
            state <= ST_DIVL;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        ST_DIVL: begin
          rem  <= rr_ge ? rr_diff[TOTAL_W-1:0] : rr[TOTAL_W-1:0];
          quo  <= {quo[LOAD_W-2:0], rr_ge};
          nlow <= {nlow[LOAD_W-2:0], 1'b0};
          if (cnt == STEP_W'(LOAD_W - 1)) begin
            cnt   <= '0;
            state <= ST_UPDATE;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        ST_UPDATE: begin
          // Replace the oldest sample and advance the ring slot
          ring_vld[pos_eff] <= 1'b1;
          window_sum        <= window_sum_next;
          pos       <= (pos_inc >= n_eff) ? '0 : pos_inc[RING_AW-1:0];
          inst_load <= load;
          avg_sr    <= window_sum_next;
          arem      <= '0;
          cnt       <= '0;
          state     <= ST_DIVA;
        end
        ST_DIVA: begin
          arem   <= arr_ge ? arr_diff[WLEN_W-1:0] : arr[WLEN_W-1:0];
          avg_sr <= {avg_sr[SUM_W-2:0], arr_ge};
          if (cnt == STEP_W'(SUM_W - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_inst  <= inst_load;
            out_avg   <= avg_sr[LOAD_W-1:0];
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the CPU load window average core.
`timescale 1ns / 100ps

module tb;
  import cpuavg_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 150;
  localparam int PRINT_CAP   = 100;
  localparam int LOAD_FULL   = 2**LOAD_W - 1;

  typedef struct packed {
    logic [CNT_W-1:0] idle;
    logic [CNT_W-1:0] kernel;
    logic [CNT_W-1:0] user;
  } snap_t;

  typedef struct packed {
    logic [LOAD_W-1:0] instant;
    logic [LOAD_W-1:0] average;
  } load_pair_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [WLEN_W-1:0] cfg_data;

  cpuavg_sample_if sample_ch ();
  cpuavg_result_if result_ch ();

  cpu_load_window_average_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // Snapshots waiting to be sent and loads waiting to come back
  snap_t      pending_snaps[$];
  load_pair_t load_exp_q[$];
  snap_t      gen_last;

  // Mirror of the block's state
  logic [CNT_W-1:0]  last_idle, last_kernel, last_user;
  logic [LOAD_W-1:0] ring_mem [MAX_WINDOW];
  int unsigned       ring_pos, ring_sum, win_len;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        flood_hold    = 1'b0;
  logic        hold_off;
  int unsigned mismatch_cnt  = 0;
  int unsigned snaps_queued  = 0;
  int unsigned beats_in      = 0;
  int unsigned results_seen  = 0;
  int unsigned windows_used  = 0;
  int unsigned cycle_cnt     = 0;

  always #CLK_HALF clk = ~clk;

  task automatic log_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Advance the mirror by one snapshot and return the loads it yields
  function automatic load_pair_t compute_loads(input snap_t s);
    logic [CNT_W-1:0]    d_idle, d_kern, d_user;
    logic [TOTAL_W-1:0]  total, busy;
    logic [SCALED_W-1:0] scaled;
    int unsigned         n;
    load_pair_t          r;
    d_idle = s.idle - last_idle;
    d_kern = s.kernel - last_kernel;
    d_user = s.user - last_user;
    total  = {1'b0, d_kern} + {1'b0, d_user};
    if (total == '0 || {1'b0, d_idle} > total) begin
      r.instant = '0;
    end else begin
      busy      = total - {1'b0, d_idle};
      scaled    = SCALED_W'(busy) * SCALED_W'(LOAD_FULL);
      r.instant = LOAD_W'(scaled / SCALED_W'(total));
    end
    last_idle   = s.idle;
    last_kernel = s.kernel;
    last_user   = s.user;
    n = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
    if (ring_pos >= n) ring_pos = 0;
    ring_sum = ring_sum - ring_mem[ring_pos] + r.instant;
    ring_mem[ring_pos] = r.instant;
    ring_pos++;
    if (ring_pos >= n) ring_pos = 0;
    r.average = LOAD_W'(ring_sum / n);
    return r;
  endfunction

  function automatic void clear_ring();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_pos = 0;
    ring_sum = 0;
  endfunction

  function automatic void push_snap(input snap_t s);
    pending_snaps.push_back(s);
    gen_last = s;
    snaps_queued++;
  endfunction

  function automatic void push_delta(input logic [CNT_W-1:0] di, dk, du);
    snap_t s;
    s.idle   = gen_last.idle + di;
    s.kernel = gen_last.kernel + dk;
    s.user   = gen_last.user + du;
    push_snap(s);
  endfunction

  function automatic logic [CNT_W-1:0] rand_span();
    case ($urandom_range(3))
      0:       return CNT_W'($urandom_range(15));
      1:       return CNT_W'($urandom);
      2:       return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly plausible counter growth, plus the corner cases and raw noise
  function automatic void add_random_item();
    logic [CNT_W-1:0] di, dk, du;
    int unsigned      roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      dk = rand_span();
      du = rand_span();
      if ($urandom_range(1) == 1) di = (dk >> 8) * $urandom_range(255);
      else di = dk >> $urandom_range(64);
      push_delta(di, dk, du);
    end else if (roll < 78) begin
      push_delta(($urandom_range(1) == 1) ? rand_span() : '0, '0, '0);
    end else if (roll < 88) begin
      dk = rand_span() >> 2;
      du = rand_span() >> 2;
      di = dk + du + 1 + (rand_span() >> 2);
      push_delta(di, dk, du);
    end else begin
      push_snap({{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}});
    end
  endfunction

  // Write the window length and clear the mirrored ring
  task automatic set_window(input logic [WLEN_W-1:0] v);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    win_len = v;
    clear_ring();
    windows_used++;
  endtask

  // Wait until every queued snapshot is accepted and its result checked
  task automatic wait_drained();
    while (beats_in != snaps_queued || load_exp_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input logic [WLEN_W-1:0] win, input int unsigned idle_p,
                           input int unsigned stall_p, input int count, input logic flood);
    wait_drained();
    set_window(win);
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    flood_hold    = flood;
    repeat (count) add_random_item();
    wait_drained();
  endtask

  // Driver: predict on each accepted beat, then offer the next snapshot
  always @(posedge clk) begin : drive_snapshots
    snap_t nxt;
    snap_t seen;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        seen.idle   = sample_ch.idle_total;
        seen.kernel = sample_ch.kernel_total;
        seen.user   = sample_ch.user_total;
        load_exp_q.push_back(compute_loads(seen));
        beats_in++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_snaps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_snaps.pop_front();
          sample_ch.valid        <= 1'b1;
          sample_ch.idle_total   <= nxt.idle;
          sample_ch.kernel_total <= nxt.kernel;
          sample_ch.user_total   <= nxt.user;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expected pair
  always @(posedge clk) begin : check_results
    load_pair_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (load_exp_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result: instant %0d average %0d",
                                 result_ch.instant_load, result_ch.average_load));
        end else begin
          want = load_exp_q.pop_front();
          if (result_ch.instant_load !== want.instant)
            log_mismatch($sformatf("instant_load %0d, expected %0d",
                                   result_ch.instant_load, want.instant));
          if (result_ch.average_load !== want.average)
            log_mismatch($sformatf("average_load %0d, expected %0d",
                                   result_ch.average_load, want.average));
          results_seen++;
        end
      end
      result_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold off the receiver once for a long stretch so the core backs up
  initial begin : receiver_holdoff
    hold_off = 1'b0;
    wait (flood_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               load_exp_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] ones;
    ones = '1;
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.idle_total   = '0;
    sample_ch.kernel_total = '0;
    sample_ch.user_total   = '0;
    result_ch.ready        = 1'b0;
    gen_last               = '0;
    last_idle              = '0;
    last_kernel            = '0;
    last_user              = '0;
    win_len                = 1;
    clear_ring();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed corners at the reset window length
    push_snap('0);                                  // zero total
    push_delta(64'd10, 64'd30, 64'd20);             // ordinary load
    push_delta(64'd1000, 64'd10, 64'd10);           // idle above total
    push_delta('0, 64'd100, '0);                    // fully busy
    push_delta('0, ones, ones);                     // total needs 65 bits
    push_delta(ones, ones, ones);                   // wide total, half busy
    push_delta(ones, ones, 64'd1);                  // total just past 64 bits
    push_delta(ones, ones, '0);                     // idle equals total
    push_delta('0, 64'd1, '0);                      // smallest nonzero total
    push_delta(64'd1, '0, 64'd1);                   // idle equals small total
    push_delta(64'd2, '0, 64'd1);                   // idle just above total
    push_snap({ones, ones, ones});                  // all counters at max
    push_snap('0);                                  // every counter wraps
    push_delta(64'd5, 64'd5, '0);                   // no busy time
    push_delta('0, '0, '0);                         // unchanged snapshot
    push_delta(64'd1, 64'd2, 64'd1);
    push_snap({64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
               64'hAAAA_AAAA_AAAA_AAAA});
    push_snap({64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
               64'h5555_5555_5555_5555});
    push_delta(64'd3, 64'd255, '0);
    push_delta('0, 64'd1, ones);
    wait_drained();

    // Random phases over window settings and idling patterns
    run_phase(9'd0,   0,  0,  150, 1'b0);
    run_phase(9'd256, 53, 0,  300, 1'b0);
    run_phase(9'd511, 0,  53, 100, 1'b0);
    run_phase(9'd7,   24, 24, 200, 1'b0);
    run_phase(9'd1,   0,  0,  100, 1'b1);
    run_phase(9'd300, 53, 0,  100, 1'b0);
    run_phase(9'd33,  0,  53, 200, 1'b0);
    run_phase(9'd255, 24, 24, 200, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d snapshot beats and %0d checked results across %0d window writes,",
             beats_in, results_seen, windows_used);
    $display("including zero, oversized and full windows, counter wrap and saturated loads.");
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cpuavg_pkg.sv
src/cpuavg_sample_if.sv
src/cpuavg_ram.sv
src/cpu_load_window_average_core.sv
tb/tb.sv
